// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/cpv_pkg.sv -----
// ----------------------------------------------------------------------------
// cpv_pkg
// shared constants, types and helpers for the consensus base vote block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpv_pkg;

   localparam int MAX_READS   = 256;
   localparam int CNT_W       = $clog2(MAX_READS + 1);
   localparam int SCORE_SCALE = 10;
   localparam int SCORE_W     = $clog2(SCORE_SCALE + 1);
   localparam int STEP_W      = (SCORE_W > 1) ? $clog2(SCORE_W) : 1;
   localparam int DIV_W       = CNT_W + SCORE_W;
   localparam int NUM_BASES   = 4;
   localparam int BASE_W      = 2;
   localparam int SYM_W       = 8;
   localparam int QPTR_W      = 2;
   localparam int QUEUE_DEPTH = 2 ** QPTR_W;
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [SYM_W-1:0] SYM_A   = 8'd65;
   localparam logic [SYM_W-1:0] SYM_C   = 8'd67;
   localparam logic [SYM_W-1:0] SYM_G   = 8'd71;
   localparam logic [SYM_W-1:0] SYM_T   = 8'd84;
   localparam logic [SYM_W-1:0] SYM_GAP = 8'd45;

   // one finished column as handed from the counting side to the scoring side
   typedef struct packed {
      logic                                cluster_end;
      logic [CNT_W-1:0]                    non_gap;
      logic [NUM_BASES-1:0][CNT_W-1:0]     counts;
   } col_rec_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_DONE
   } back_state_type;

   function automatic logic [SYM_W-1:0] base_sym(input logic [BASE_W-1:0] idx);
      logic [SYM_W-1:0] s;
      case (idx)
         2'd0:    s = SYM_A;
         2'd1:    s = SYM_C;
         2'd2:    s = SYM_G;
         default: s = SYM_T;
      endcase
      return s;
   endfunction

   function automatic logic [DIV_W-1:0] scale_count(input logic [CNT_W-1:0] c);
      logic [DIV_W-1:0] r;
      r = DIV_W'(c) * DIV_W'(SCORE_SCALE);
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pileup_consensus_base_vote.sv -----
// path: after its last item is accepted, a column's record goes through the queue,
//   the idle, divide and done states and the output register (all-gap: no divide)
// throughput: read symbols are taken one per cycle while the 4-entry column queue
//   has room; the back end scores one column at a time on one shared
//   4-step restoring divider (4 bases x 4 quotient bits)
// reset: synchronous, clears counters, queue and output register
// ----------------------------------------------------------------------------
// pileup_consensus_base_vote
// per-column base vote over a read pileup, counting front end and scoring back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pileup_consensus_base_vote (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,  // [7:0] base_symbol
   input  wire logic                       req_tlast,  // column_end
   input  wire logic                       req_tuser,  // [0] cluster_end
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [7:0] consensus_symbol
   output logic                            rsp_tlast,  // last_of_cluster
   output logic                            rsp_tuser   // [0] column_has_bases
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_valid;
   cpv_pkg::col_rec_type   push_rec;
   cpv_pkg::col_rec_type   pop_rec;

   cpv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (push_rec)
   );

   cpv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_rec  (pop_rec)
   );

   cpv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rec      (pop_rec),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/cpv_front.sv -----
// ----------------------------------------------------------------------------
// cpv_front
// counts bases and non-gap symbols per column, emits a record at column end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cpv_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [cpv_pkg::SYM_W-1:0]       req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tuser,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output cpv_pkg::col_rec_type                 q_rec
);

   logic [cpv_pkg::NUM_BASES-1:0][cpv_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [cpv_pkg::CNT_W-1:0]                         non_gap_ff, non_gap_in;
   logic [cpv_pkg::NUM_BASES-1:0][cpv_pkg::CNT_W-1:0] cnt_next;
   logic [cpv_pkg::CNT_W-1:0]                         non_gap_next;
   logic                                              accept;

   function automatic logic [cpv_pkg::CNT_W-1:0] sat_inc(
      input logic [cpv_pkg::CNT_W-1:0] v,
      input logic                      hit
   );
      logic [cpv_pkg::CNT_W-1:0] r;
      if (hit && (v < cpv_pkg::CNT_W'(cpv_pkg::MAX_READS))) begin
         r = v + cpv_pkg::CNT_W'(1);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int b = 0; b < cpv_pkg::NUM_BASES; b++) begin
         cnt_next[b] = sat_inc(cnt_ff[b],
                               req_tdata == cpv_pkg::base_sym(cpv_pkg::BASE_W'(b)));
      end
      non_gap_next = sat_inc(non_gap_ff, req_tdata != cpv_pkg::SYM_GAP);
   end

   always_comb begin
      cnt_in     = cnt_ff;
      non_gap_in = non_gap_ff;
      if (accept) begin
         if (req_tlast) begin
            cnt_in     = '0;
            non_gap_in = '0;
         end else begin
            cnt_in     = cnt_next;
            non_gap_in = non_gap_next;
         end
      end
   end

   // the column's last item is counted into the record it closes
   assign q_push              = accept && req_tlast;
   assign q_rec.cluster_end   = req_tuser;
   assign q_rec.non_gap       = non_gap_next;
   assign q_rec.counts        = cnt_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         non_gap_ff <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         non_gap_ff <= non_gap_in;
      end
   end

   `ASSERT_ALWAYS(a_front_sat, clock, reset,
      non_gap_ff <= cpv_pkg::CNT_W'(cpv_pkg::MAX_READS))
   `ASSERT_IMPLIES(a_front_base_le_total, clock, reset, 1'b1,
      (cnt_ff[0] <= non_gap_ff) && (cnt_ff[1] <= non_gap_ff) &&
      (cnt_ff[2] <= non_gap_ff) && (cnt_ff[3] <= non_gap_ff))

endmodule

`default_nettype wire

// ----- hw/rtl/cpv_queue.sv -----
// ----------------------------------------------------------------------------
// cpv_queue
// short first-in first-out queue of column records between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cpv_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cpv_pkg::col_rec_type push_rec,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output cpv_pkg::col_rec_type      pop_rec
);

   cpv_pkg::col_rec_type             entry_ff [cpv_pkg::QUEUE_DEPTH];
   logic [cpv_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cpv_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cpv_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign full    = (count_ff == cpv_pkg::QCNT_W'(cpv_pkg::QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_rec = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + cpv_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + cpv_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + cpv_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - cpv_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_queue_count_bound, clock, reset,
      count_ff <= cpv_pkg::QCNT_W'(cpv_pkg::QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_queue_ptr_gap, clock, reset, (count_ff != '0) && !full,
      wr_ptr_ff != rd_ptr_ff)

endmodule

`default_nettype wire

// ----- hw/rtl/cpv_back.sv -----
// ----------------------------------------------------------------------------
// cpv_back
// scores a column's four bases on a shared restoring divider, picks one or gap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cpv_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire cpv_pkg::col_rec_type            q_rec,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [cpv_pkg::SYM_W-1:0]            rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);

   cpv_pkg::back_state_type            state_ff, state_in;
   cpv_pkg::col_rec_type               rec_ff, rec_in;
   logic [cpv_pkg::BASE_W-1:0]         base_ff, base_in;
   logic [cpv_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [cpv_pkg::DIV_W-1:0]          rem_ff, rem_in;
   logic [cpv_pkg::SCORE_W-1:0]        quo_ff, quo_in;
   logic [cpv_pkg::SCORE_W-1:0]        best_ff, best_in;
   logic [cpv_pkg::SYM_W-1:0]          pick_ff, pick_in;
   logic                               out_valid_ff, out_valid_in;
   logic [cpv_pkg::SYM_W-1:0]          out_sym_ff, out_sym_in;
   logic                               out_has_ff, out_has_in;
   logic                               out_last_ff, out_last_in;

   logic [cpv_pkg::DIV_W-1:0]          div_shift;
   logic                               div_ge;
   logic [cpv_pkg::SCORE_W-1:0]        score;
   logic                               out_free;
   logic                               last_step;
   logic                               last_base;

   assign div_shift = cpv_pkg::DIV_W'(rec_ff.non_gap) << step_ff;
   assign div_ge    = (rem_ff >= div_shift);
   assign score     = {quo_ff[cpv_pkg::SCORE_W-2:0], div_ge};
   assign out_free  = !out_valid_ff || rsp_tready;
   assign last_step = (step_ff == '0);
   assign last_base = (base_ff == cpv_pkg::BASE_W'(cpv_pkg::NUM_BASES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpv_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = (q_rec.non_gap == '0) ? cpv_pkg::BK_DONE : cpv_pkg::BK_DIVIDE;
            end
         end
         cpv_pkg::BK_DIVIDE: begin
            if (last_step && last_base) begin
               state_in = cpv_pkg::BK_DONE;
            end
         end
         cpv_pkg::BK_DONE: begin
            if (out_free) begin
               state_in = cpv_pkg::BK_IDLE;
            end
         end
         default: state_in = cpv_pkg::BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      rec_in       = rec_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_sym_in   = out_sym_ff;
      out_has_in   = out_has_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         cpv_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               rec_in  = q_rec;
               base_in = '0;
               step_in = cpv_pkg::STEP_W'(cpv_pkg::SCORE_W - 1);
               rem_in  = cpv_pkg::scale_count(q_rec.counts[0]);
               quo_in  = '0;
               best_in = '0;
               pick_in = cpv_pkg::SYM_GAP;
            end
         end
         cpv_pkg::BK_DIVIDE: begin
            rem_in = div_ge ? rem_ff - div_shift : rem_ff;
            quo_in = score;
            if (last_step) begin
               // strictly higher wins, so the earliest base keeps a tie
               if (score > best_ff) begin
                  best_in = score;
                  pick_in = cpv_pkg::base_sym(base_ff);
               end
               if (!last_base) begin
                  base_in = base_ff + cpv_pkg::BASE_W'(1);
                  step_in = cpv_pkg::STEP_W'(cpv_pkg::SCORE_W - 1);
                  rem_in  = cpv_pkg::scale_count(
                               rec_ff.counts[base_ff + cpv_pkg::BASE_W'(1)]);
                  quo_in  = '0;
               end
            end else begin
               step_in = step_ff - cpv_pkg::STEP_W'(1);
            end
         end
         cpv_pkg::BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sym_in   = pick_ff;
               out_has_in   = (rec_ff.non_gap != '0);
               out_last_in  = rec_ff.cluster_end;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tuser  = out_has_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpv_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      base_ff     <= base_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      out_sym_ff  <= out_sym_in;
      out_has_ff  <= out_has_in;
      out_last_ff <= out_last_in;
   end

   `ASSERT_IMPLIES(a_back_no_div_zero, clock, reset, state_ff == cpv_pkg::BK_DIVIDE,
      rec_ff.non_gap != '0)
   `ASSERT_IMPLIES(a_back_score_bound, clock, reset, state_ff == cpv_pkg::BK_DONE,
      best_ff <= cpv_pkg::SCORE_W'(cpv_pkg::SCORE_SCALE))

endmodule

`default_nettype wire

// ----- test/pileup_consensus_base_vote_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_consensus_base_vote_tb
// streams pileup columns into the vote block through a bursty sender and a
// stalling receiver, predicts each column's consensus base and checks every
// result item in order
// ----------------------------------------------------------------------------

module pileup_consensus_base_vote_tb;

   localparam int ITEM_TARGET = 1600;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      logic [cpv_pkg::SYM_W-1:0] sym;
      logic                      col_end;
      logic                      clu_end;
   } read_sym_type;

   typedef struct {
      logic [cpv_pkg::SYM_W-1:0] sym;
      logic                      has_bases;
      logic                      last;
   } vote_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;   // [7:0] base_symbol
   logic             req_tlast = 1'b0; // column_end
   logic             req_tuser = 1'b0; // [0] cluster_end
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // [7:0] consensus_symbol
   logic             rsp_tlast;        // last_of_cluster
   logic             rsp_tuser;        // [0] column_has_bases

   read_sym_type     pending_reads[$];
   vote_type         consensus_due[$];
   int               items_queued = 0;
   int               error_count = 0;
   int               idle_cycles = 0;
   logic             req_taken = 1'b0;
   int               burst_left = 0;
   int               gap_left = 0;
   logic [15:0]      stall_pattern = 16'hFFFF;
   int               stall_phase = 0;

   // predictor state
   logic [cpv_pkg::CNT_W-1:0] tally_a, tally_c, tally_g, tally_t, tally_non_gap;

   pileup_consensus_base_vote i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [cpv_pkg::CNT_W-1:0] sat_bump(
      input logic [cpv_pkg::CNT_W-1:0] v
   );
      return (v < cpv_pkg::CNT_W'(cpv_pkg::MAX_READS)) ? v + 1'b1
                                                       : cpv_pkg::CNT_W'(cpv_pkg::MAX_READS);
   endfunction

   function automatic logic [cpv_pkg::SYM_W-1:0] base_of(input int k);
      case (k)
         0:       return cpv_pkg::SYM_A;
         1:       return cpv_pkg::SYM_C;
         2:       return cpv_pkg::SYM_G;
         default: return cpv_pkg::SYM_T;
      endcase
   endfunction

   function automatic logic [cpv_pkg::SYM_W-1:0] pick_symbol(input int dom);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)      return base_of(dom);
      else if (r < 70) return base_of($urandom_range(0, 3));
      else if (r < 82) return cpv_pkg::SYM_GAP;
      else if (r < 90) return cpv_pkg::SYM_W'($urandom_range(8'h61, 8'h7a));
      else             return cpv_pkg::SYM_W'($urandom_range(0, 255));
   endfunction

   // count one accepted read symbol; on column end work out the vote
   task automatic take_symbol(input logic [cpv_pkg::SYM_W-1:0] sym, input logic col_end,
                              input logic clu_end);
      vote_type                      v;
      logic [cpv_pkg::CNT_W-1:0]     tallies[cpv_pkg::NUM_BASES];
      int                            score;
      int                            best;
      if (sym == cpv_pkg::SYM_A)      tally_a = sat_bump(tally_a);
      else if (sym == cpv_pkg::SYM_C) tally_c = sat_bump(tally_c);
      else if (sym == cpv_pkg::SYM_G) tally_g = sat_bump(tally_g);
      else if (sym == cpv_pkg::SYM_T) tally_t = sat_bump(tally_t);
      if (sym != cpv_pkg::SYM_GAP) tally_non_gap = sat_bump(tally_non_gap);
      if (!col_end) return;
      v.last      = clu_end;
      v.sym       = cpv_pkg::SYM_GAP;
      v.has_bases = (tally_non_gap != 0);
      if (v.has_bases) begin
         tallies[0] = tally_a;
         tallies[1] = tally_c;
         tallies[2] = tally_g;
         tallies[3] = tally_t;
         best = 0;
         for (int k = 0; k < cpv_pkg::NUM_BASES; k++) begin
            score = (int'(tallies[k]) * cpv_pkg::SCORE_SCALE) / int'(tally_non_gap);
            // first strictly highest wins, so ties go to the earlier base
            if (score > best) begin
               best  = score;
               v.sym = base_of(k);
            end
         end
      end
      consensus_due = {consensus_due, v};
      tally_a       = '0;
      tally_c       = '0;
      tally_g       = '0;
      tally_t       = '0;
      tally_non_gap = '0;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got 'h%0h expected 'h%0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic add_item(input logic [cpv_pkg::SYM_W-1:0] sym, input logic col_end,
                           input logic clu_end);
      read_sym_type r;
      r.sym     = sym;
      r.col_end = col_end;
      r.clu_end = clu_end;
      pending_reads = {pending_reads, r};
      items_queued++;
   endtask

   // cluster_end on a non-final item should be ignored, so set it now and then
   task automatic add_column(input logic [cpv_pkg::SYM_W-1:0] syms[$]);
      for (int i = 0; i < syms.size(); i++) begin
         if (i == syms.size() - 1)
            add_item(syms[i], 1'b1, $urandom_range(0, 5) == 0);
         else
            add_item(syms[i], 1'b0, $urandom_range(0, 7) == 0);
      end
   endtask

   // sender: bursts of items with random gaps, next item put up on the falling edge
   always @(negedge clock) begin : drive_req
      read_sym_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reads.size() != 0) begin
            r = pending_reads.pop_front();
            req_tdata  <= r.sym;
            req_tlast  <= r.col_end;
            req_tuser  <= r.clu_end;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: rotating stall pattern, reloaded every so often in a new mode
   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
      end else begin
         if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= 16'hFFFF;
               1:       stall_pattern <= 16'($urandom);
               2:       stall_pattern <= 16'($urandom) & 16'($urandom);
               default: stall_pattern <= 16'($urandom) | 16'($urandom);
            endcase
            rsp_tready <= 1'b1;
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            rsp_tready    <= stall_pattern[0];
         end
         stall_phase <= (stall_phase == 95) ? 0 : stall_phase + 1;
      end
   end

   always @(posedge clock) begin : watch_ports
      vote_type v;
      if (reset) begin
         req_taken     <= 1'b0;
         idle_cycles   <= 0;
         tally_a       = '0;
         tally_c       = '0;
         tally_g       = '0;
         tally_t       = '0;
         tally_non_gap = '0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (consensus_due.size() == 0) begin
               report_mismatch("unexpected result item", rsp_tdata, 0);
            end else begin
               v = consensus_due.pop_front();
               if (rsp_tdata != v.sym)
                  report_mismatch("consensus_symbol", rsp_tdata, v.sym);
               if (rsp_tuser != v.has_bases)
                  report_mismatch("column_has_bases", rsp_tuser, v.has_bases);
               if (rsp_tlast != v.last)
                  report_mismatch("last_of_cluster", rsp_tlast, v.last);
            end
         end
         if (req_tvalid && req_tready)
            take_symbol(req_tdata, req_tlast, req_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic [cpv_pkg::SYM_W-1:0] col[$];
      int               kind;
      int               len;
      int               dom;
      int               b1;
      int               b2;
      logic             long_t_done;
      logic             long_noise_done;

      long_t_done     = 1'b0;
      long_noise_done = 1'b0;

      // single base columns, cluster end on C and T
      add_item(cpv_pkg::SYM_A, 1'b1, 1'b0);
      add_item(cpv_pkg::SYM_C, 1'b1, 1'b1);
      add_item(cpv_pkg::SYM_G, 1'b1, 1'b0);
      add_item(cpv_pkg::SYM_T, 1'b1, 1'b1);
      // all-gap columns, one with cluster end on a non-final item
      add_item(cpv_pkg::SYM_GAP, 1'b1, 1'b1);
      add_item(cpv_pkg::SYM_GAP, 1'b0, 1'b1);
      add_item(cpv_pkg::SYM_GAP, 1'b0, 1'b0);
      add_item(cpv_pkg::SYM_GAP, 1'b1, 1'b0);
      // only non-base symbols: lowercase, N and byte extremes
      add_item(8'h61, 1'b0, 1'b0);
      add_item(8'h4e, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b0);
      add_item(8'hff, 1'b1, 1'b1);
      // tie between C and A goes to A
      add_item(cpv_pkg::SYM_C, 1'b0, 1'b0);
      add_item(cpv_pkg::SYM_A, 1'b1, 1'b0);
      // one A among ten others scores zero
      add_item(cpv_pkg::SYM_A, 1'b0, 1'b0);
      for (int i = 0; i < 9; i++)
         add_item(8'h6e, 1'b0, 1'b0);
      add_item(8'h6e, 1'b1, 1'b0);

      while (items_queued < ITEM_TARGET) begin
         col.delete();
         if (!long_t_done && items_queued >= 400) begin
            // T and non-gap counters both saturate
            long_t_done = 1'b1;
            for (int i = 0; i < 300; i++)
               col = {col, (i < 5) ? cpv_pkg::SYM_G
                               : ((i % 17 == 0) ? cpv_pkg::SYM_GAP : cpv_pkg::SYM_T)};
         end else if (!long_noise_done && items_queued >= 1000) begin
            // saturated non-gap total swamps a few C reads
            long_noise_done = 1'b1;
            for (int i = 0; i < 300; i++)
               col = {col, (i % 15 == 0) ? cpv_pkg::SYM_C : 8'h78};
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
               len = $urandom_range(1, 20);
               dom = $urandom_range(0, 3);
               for (int i = 0; i < len; i++)
                  col = {col, pick_symbol(dom)};
            end else if (kind < 75) begin
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++)
                  col = {col, cpv_pkg::SYM_W'($urandom_range(0, 255))};
            end else if (kind < 85) begin
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++)
                  col = {col, ($urandom_range(0, 4) == 0) ? pick_symbol(0)
                                                          : cpv_pkg::SYM_GAP};
            end else begin
               // two bases with equal counts, at times followed by one more symbol
               len = $urandom_range(1, 6);
               b1  = $urandom_range(0, 3);
               b2  = (b1 + $urandom_range(1, 3)) % 4;
               for (int i = 0; i < 2 * len; i++)
                  col = {col, base_of((i % 2 == 0) ? b1 : b2)};
               if ($urandom_range(0, 2) == 0)
                  col = {col, pick_symbol(b1)};
            end
         end
         add_column(col);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reads.size() != 0 || req_tvalid)
         @(posedge clock);
      while (consensus_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && consensus_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cpv_pkg.sv
hw/rtl/cpv_front.sv
hw/rtl/cpv_queue.sv
hw/rtl/cpv_back.sv
hw/rtl/pileup_consensus_base_vote.sv
test/pileup_consensus_base_vote_tb.sv
